// ===== rtl/uer_pkg.sv =====
package uer_pkg;

  // header store geometry
  localparam int HDR_BYTES = 42;
  localparam int HDR_AW    = $clog2(HDR_BYTES);

  // frame length thresholds for the ordered checks
  localparam int ETH_MIN_BYTES = 14;
  localparam int IP_MIN_BYTES  = 34;

  // byte offsets within the frame
  localparam int OFS_ETYPE_HI = 12;
  localparam int OFS_ETYPE_LO = 13;
  localparam int OFS_VER_IHL  = 14;
  localparam int OFS_PROTO    = 23;
  localparam int OFS_CSUM_HI  = 24;
  localparam int OFS_CSUM_LO  = 25;
  localparam int OFS_IP_END   = 33;
  localparam int OFS_DPORT_HI = 36;
  localparam int OFS_DPORT_LO = 37;
  localparam int OFS_UCSUM_HI = 40;
  localparam int OFS_UCSUM_LO = 41;

  // protocol constants
  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [3:0]  IPV4_VERSION    = 4'd4;
  localparam logic [3:0]  IPV4_IHL        = 4'd5;
  localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;
  localparam logic [15:0] ECHO_PORT_RESET = 16'd45954;

  // verdict codes
  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_PASS  = 2'd0;
  localparam verdict_t VERDICT_ECHO  = 2'd1;
  localparam verdict_t VERDICT_ABORT = 2'd2;

  // parser result handed to the control
  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] csum;
  } uer_status_t;

endpackage

// ===== rtl/uer_rx_if.sv =====
interface uer_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// ===== rtl/uer_tx_if.sv =====
interface uer_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;
  logic [1:0] verdict;

  modport source (output valid, output out_byte, output out_end, output verdict,
                  input ready);
  modport sink   (input valid, input out_byte, input out_end, input verdict,
                  output ready);
endinterface

// ===== rtl/uer_hdr_mem.sv =====
module uer_hdr_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [uer_pkg::HDR_AW-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic                      rd_en,
  input  logic [uer_pkg::HDR_AW-1:0] rd_addr,
  output logic [7:0]                rd_data
);
  import uer_pkg::*;

  logic [7:0] mem [HDR_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/uer_parse.sv =====
module uer_parse (
  input  logic                       clk,
  input  logic                       cap_en,
  input  logic [uer_pkg::HDR_AW-1:0]  cap_idx,
  input  logic [7:0]                 cap_byte,
  input  logic [uer_pkg::HDR_AW-1:0]  held_n,
  input  logic [15:0]                echo_port,
  output uer_pkg::uer_status_t       status
);
  import uer_pkg::*;

  logic [7:0]  etype_hi, etype_lo, ver_ihl, proto, dport_hi, dport_lo;
  logic [19:0] sum, sum_next;
  logic [15:0] add_word;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // running ip header sum, checksum field left out
  always_comb begin
    add_word = 16'd0;
    if (cap_idx inside {[OFS_VER_IHL:OFS_CSUM_HI-1], [OFS_CSUM_LO+1:OFS_IP_END]}) begin
      add_word = cap_idx[0] ? {8'd0, cap_byte} : {cap_byte, 8'd0};
    end
    sum_next = (cap_idx == '0) ? 20'd0 : sum + {4'd0, add_word};
  end

  always_ff @(posedge clk) begin
    if (cap_en) begin
      sum <= sum_next;
      if (cap_idx == HDR_AW'(OFS_ETYPE_HI)) etype_hi <= cap_byte;
      if (cap_idx == HDR_AW'(OFS_ETYPE_LO)) etype_lo <= cap_byte;
      if (cap_idx == HDR_AW'(OFS_VER_IHL))  ver_ihl  <= cap_byte;
      if (cap_idx == HDR_AW'(OFS_PROTO))    proto    <= cap_byte;
      if (cap_idx == HDR_AW'(OFS_DPORT_HI)) dport_hi <= cap_byte;
      if (cap_idx == HDR_AW'(OFS_DPORT_LO)) dport_lo <= cap_byte;
    end
  end

  always_comb begin
    // two end-around folds cover a 20 bit sum
    fold1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
    status.csum = ~fold2;

    if (held_n < HDR_AW'(ETH_MIN_BYTES)) begin
      status.verdict = VERDICT_ABORT;
    end else if ({etype_hi, etype_lo} != ETHERTYPE_IPV4) begin
      status.verdict = VERDICT_PASS;
    end else if (held_n < HDR_AW'(IP_MIN_BYTES)) begin
      status.verdict = VERDICT_ABORT;
    end else if (ver_ihl[7:4] != IPV4_VERSION || ver_ihl[3:0] != IPV4_IHL ||
                 proto != IP_PROTO_UDP) begin
      status.verdict = VERDICT_PASS;
    end else if (held_n < HDR_AW'(HDR_BYTES)) begin
      status.verdict = VERDICT_ABORT;
    end else if ({dport_hi, dport_lo} != echo_port) begin
      status.verdict = VERDICT_PASS;
    end else begin
      status.verdict = VERDICT_ECHO;
    end
  end

endmodule

// ===== rtl/udp_echo_packet_reflector_unit.sv =====
// UDP echo reflector. Frames arrive one byte per word on rx and leave on tx
// in the same order. The first 42 bytes of a frame (fewer if the frame ends
// earlier) are written one per cycle into a 42-byte header memory while a
// parser picks up the ethertype, IPv4 version/IHL, protocol and UDP
// destination port and keeps a running IPv4 header sum. In the DECIDE state
// after the last header byte the verdict (pass, echo, abort on short frame)
// is fixed; then the held bytes are released one by one, each through the
// memory's registered read (READ) followed by the output register load
// (LOAD, which waits until tx can take a word), during which rx is held off.
// After the header, the rest of the frame passes at one byte per cycle when
// tx takes every word at once. On echo the MAC, IP and UDP port fields are
// read from swapped addresses, the IPv4 checksum is replaced and the UDP
// checksum is zeroed; every word carries the frame's verdict. echo_port is
// written through cfg_we/cfg_wdata and resets to 45954.
module udp_echo_packet_reflector_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  uer_rx_if.sink      rx,
  uer_tx_if.source    tx
);
  import uer_pkg::*;

  // control states
  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_READ    = 3'd2;
  localparam logic [2:0] S_LOAD    = 3'd3;
  localparam logic [2:0] S_PASS    = 3'd4;

  localparam logic [HDR_AW-1:0] LAST_IDX = HDR_AW'(HDR_BYTES - 1);

  logic [2:0]        state;
  logic [HDR_AW-1:0] count;       // write address while collecting
  logic [HDR_AW-1:0] held_n;      // bytes held for this frame
  logic [HDR_AW-1:0] emit_idx;    // header byte being released
  logic              last_flag;   // frame ended inside the header
  logic [15:0]       echo_port;
  verdict_t          frame_verdict;
  logic [15:0]       csum;

  // output register
  logic              ob_valid;
  logic [7:0]        ob_byte;
  logic              ob_end;
  verdict_t          ob_verdict;

  logic              out_free;
  logic              rx_acc;
  logic              col_acc;
  logic              pass_acc;
  logic              load_hdr;
  logic              hdr_done;
  logic [HDR_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        hdr_byte;
  uer_status_t       status;

  // echo reply reads the partner field of each swapped pair
  function automatic logic [HDR_AW-1:0] echo_addr(input logic [HDR_AW-1:0] idx);
    logic [HDR_AW-1:0] a;
    a = idx;
    if (idx inside {[0:5]})        a = idx + HDR_AW'(6);
    else if (idx inside {[6:11]})  a = idx - HDR_AW'(6);
    else if (idx inside {[26:29]}) a = idx + HDR_AW'(4);
    else if (idx inside {[30:33]}) a = idx - HDR_AW'(4);
    else if (idx inside {[34:35]}) a = idx + HDR_AW'(2);
    else if (idx inside {[36:37]}) a = idx - HDR_AW'(2);
    return a;
  endfunction

  assign out_free = !ob_valid || tx.ready;
  assign rx.ready = (state == S_COLLECT) || ((state == S_PASS) && out_free);
  assign rx_acc   = rx.valid && rx.ready;
  assign col_acc  = rx_acc && (state == S_COLLECT);
  assign pass_acc = rx_acc && (state == S_PASS);
  assign load_hdr = (state == S_LOAD) && out_free;
  assign hdr_done = (emit_idx == held_n - HDR_AW'(1));

  assign rd_addr = (frame_verdict == VERDICT_ECHO) ? echo_addr(emit_idx) : emit_idx;

  uer_hdr_mem u_mem (
    .clk     (clk),
    .wr_en   (col_acc),
    .wr_addr (count),
    .wr_data (rx.data_byte),
    .rd_en   (state == S_READ),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  uer_parse u_parse (
    .clk       (clk),
    .cap_en    (col_acc),
    .cap_idx   (count),
    .cap_byte  (rx.data_byte),
    .held_n    (held_n),
    .echo_port (echo_port),
    .status    (status)
  );

  // checksum substitution on the way out
  always_comb begin
    hdr_byte = rd_data;
    if (frame_verdict == VERDICT_ECHO) begin
      if (emit_idx == HDR_AW'(OFS_CSUM_HI))       hdr_byte = csum[15:8];
      else if (emit_idx == HDR_AW'(OFS_CSUM_LO))  hdr_byte = csum[7:0];
      else if (emit_idx == HDR_AW'(OFS_UCSUM_HI)) hdr_byte = 8'd0;
      else if (emit_idx == HDR_AW'(OFS_UCSUM_LO)) hdr_byte = 8'd0;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_port <= ECHO_PORT_RESET;
    end else if (cfg_we) begin
      echo_port <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_COLLECT;
      count         <= '0;
      frame_verdict <= VERDICT_PASS;
    end else begin
      case (state)
        S_COLLECT: begin
          if (col_acc) begin
            if (rx.frame_end || count == LAST_IDX) begin
              state <= S_DECIDE;
              count <= '0;
            end else begin
              count <= count + HDR_AW'(1);
            end
          end
        end
        S_DECIDE: begin
          frame_verdict <= status.verdict;
          state         <= S_READ;
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (load_hdr) begin
            if (!hdr_done)      state <= S_READ;
            else if (last_flag) state <= S_COLLECT;
            else                state <= S_PASS;
          end
        end
        S_PASS: begin
          if (pass_acc && rx.frame_end) state <= S_COLLECT;
        end
        default: begin
          state <= S_COLLECT;
          count <= '0;
        end
      endcase
    end
  end

  // frame bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    if (col_acc) begin
      held_n    <= count + HDR_AW'(1);
      last_flag <= rx.frame_end;
    end
    if (state == S_DECIDE) begin
      csum     <= status.csum;
      emit_idx <= '0;
    end else if (load_hdr) begin
      emit_idx <= emit_idx + HDR_AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
    end else if (load_hdr || pass_acc) begin
      ob_valid <= 1'b1;
    end else if (tx.ready) begin
      ob_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hdr) begin
      ob_byte    <= hdr_byte;
      ob_end     <= last_flag && hdr_done;
      ob_verdict <= frame_verdict;
    end else if (pass_acc) begin
      ob_byte    <= rx.data_byte;
      ob_end     <= rx.frame_end;
      ob_verdict <= frame_verdict;
    end
  end

  assign tx.valid    = ob_valid;
  assign tx.out_byte = ob_byte;
  assign tx.out_end  = ob_end;
  assign tx.verdict  = ob_verdict;

  // write pointer never runs past the header memory
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state == S_COLLECT |-> count <= LAST_IDX)
    else $error("header write pointer out of range");

  // release never reads past the bytes held
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_LOAD) |-> emit_idx < held_n)
    else $error("header release index past held bytes");

  // echo only on a full header
  a_echo_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && frame_verdict == VERDICT_ECHO) |-> held_n == HDR_AW'(HDR_BYTES))
    else $error("echo verdict on short header");

  // a frame that ended in the header returns to collecting
  a_short_done: assert property (@(posedge clk) disable iff (rst)
    (load_hdr && hdr_done && last_flag) |=> (state == S_COLLECT && count == '0))
    else $error("no return to collect after short frame");

  // no input taken while the header is released
  a_hold_rx: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE || state == S_READ || state == S_LOAD) |-> !rx_acc)
    else $error("input taken during header release");

endmodule
